// ===== rtl/fvn_pkg.sv =====
// Shared types and constants for the fractal value noise block.
// No dependencies; imported by fvn_octave, fractal_value_noise_3d, fvn_checker and tb.
package fvn_pkg;

    // Octave count default and limits of the octave weighting
    localparam int OCTAVES_DEF = 6;
    localparam int OCT_MAX     = 8;

    // Pipeline depth of one octave unit, and of the whole block
    localparam int OCT_LAT = 8;
    localparam int BLK_LAT = OCT_LAT + 2;

    // Register reset values
    localparam logic [31:0] SEED_RST  = 32'd0;
    localparam logic [15:0] FREQ_RST  = 16'd2560;
    localparam logic        RIDGE_RST = 1'b0;

    // Lattice offsets (Q.16), corner primes, mixer constants
    localparam logic [31:0] OFF_X     = 32'd1253704;
    localparam logic [31:0] OFF_Y     = 32'd2078177;
    localparam logic [31:0] OFF_Z     = 32'd3110994;
    localparam logic [31:0] PRIME_X   = 32'd374761393;
    localparam logic [31:0] PRIME_Y   = 32'd668265263;
    localparam logic [31:0] PRIME_Z   = 32'd2147483647;
    localparam logic [31:0] MIX_A     = 32'h7feb352d;
    localparam logic [31:0] MIX_B     = 32'h846ca68b;
    localparam int          SEED_STEP = 101;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SEED   = 2'd0,
        CFG_FREQ   = 2'd1,
        CFG_RIDGED = 2'd2
    } t_cfg_idx;

    // Configuration handed to each octave unit
    typedef struct packed {
        logic [31:0] seed;
        logic [15:0] freq;
    } t_cfg;

    typedef logic signed [15:0] t_dir;

endpackage

// ===== rtl/fvn_octave.sv =====
// One octave of 3D value noise: scale, split, hash eight corners, trilinear blend.
// Depends on fvn_pkg. Takes one item per cycle.
module fvn_octave #(
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  fvn_pkg::t_dir i_dir [3],
    input  fvn_pkg::t_cfg i_cfg,
    output logic [15:0]   o_value
);
    import fvn_pkg::*;

    localparam int FW = 16 + OCT_MAX - 1;
    localparam logic [31:0] OFF [3]   = '{OFF_X, OFF_Y, OFF_Z};
    localparam logic [31:0] PRIME [3] = '{PRIME_X, PRIME_Y, PRIME_Z};

    // Floor lerp: a + floor((b - a) * s / 2^16)
    function automatic logic [15:0] lerp16(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] s);
        logic signed [16:0] d;
        logic signed [33:0] prod;
        logic signed [17:0] sum;
        d    = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = 34'(d) * 34'($signed({1'b0, s}));
        sum  = $signed({2'b00, a}) + 18'(prod >>> 16);
        return sum[15:0];
    endfunction

    logic [FW-1:0]      w_freq;
    logic [31:0]        w_seed;
    logic signed [39:0] r_p     [3];
    logic signed [33:0] w_q     [3];
    logic [31:0]        r_cell  [3];
    logic [15:0]        r_frac  [3];
    logic [31:0]        r_pr0   [3];
    logic [31:0]        r_pr1   [3];
    logic [31:0]        r_tt    [3];
    logic [15:0]        r_t3    [3];
    logic [31:0]        r_tt4   [3];
    logic [47:0]        r_ttt   [3];
    logic [31:0]        w_h0    [8];
    logic [31:0]        w_h1    [8];
    logic [31:0]        r_m1    [8];
    logic [31:0]        w_h2    [8];
    logic [31:0]        r_m2    [8];
    logic [50:0]        w_num   [3];
    logic [15:0]        r_s     [3];
    logic [15:0]        r_sy6, r_sz6, r_sz7;
    logic [15:0]        r_x     [4];
    logic [15:0]        r_y     [2];
    logic [15:0]        r_v;

    assign w_freq = FW'(i_cfg.freq) << IDX;
    assign w_seed = i_cfg.seed + 32'(IDX * SEED_STEP);

    // Stage 1: scale direction by octave frequency
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_p[a] <= 40'(i_dir[a]) * 40'($signed({1'b0, w_freq}));
        end
    end

    // Stage 2: drop to Q.16, add offset, split into cell and fraction
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_q[a] = 34'(r_p[a] >>> 9) + $signed({2'b00, OFF[a]});
        end
    end

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_cell[a] <= 32'(w_q[a] >>> 16);
            r_frac[a] <= w_q[a][15:0];
        end
    end

    // Stage 3: prime products for both corners on each axis, fraction squared
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_pr0[a] <= r_cell[a] * PRIME[a];
            r_pr1[a] <= (r_cell[a] + 32'd1) * PRIME[a];
            r_tt[a]  <= 32'(r_frac[a]) * 32'(r_frac[a]);
            r_t3[a]  <= r_frac[a];
        end
    end

    // Stage 4: combine corner hash, first mixer round; fraction cubed
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_h0[k] = w_seed ^ (k[0] ? r_pr1[0] : r_pr0[0])
                             ^ (k[1] ? r_pr1[1] : r_pr0[1])
                             ^ (k[2] ? r_pr1[2] : r_pr0[2]);
            w_h1[k] = w_h0[k] ^ (w_h0[k] >> 16);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 8; k++) begin
            r_m1[k] <= w_h1[k] * MIX_A;
        end
        for (int a = 0; a < 3; a++) begin
            r_ttt[a] <= 48'(r_tt[a]) * 48'(r_t3[a]);
            r_tt4[a] <= r_tt[a];
        end
    end

    // Stage 5: second mixer round; smoothstep weight
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_h2[k] = r_m1[k] ^ (r_m1[k] >> 15);
        end
        for (int a = 0; a < 3; a++) begin
            w_num[a] = 51'({r_tt4[a], 16'd0}) * 51'd3 - {2'b00, r_ttt[a], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 8; k++) begin
            r_m2[k] <= w_h2[k] * MIX_B;
        end
        for (int a = 0; a < 3; a++) begin
            r_s[a] <= w_num[a][47:32];
        end
    end

    // Stage 6: blend along x; corner value is the top half of the mixed hash
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 4; j++) begin
            r_x[j] <= lerp16(r_m2[2*j][31:16], r_m2[2*j+1][31:16], r_s[0]);
        end
        r_sy6 <= r_s[1];
        r_sz6 <= r_s[2];
    end

    // Stage 7: blend along y
    always_ff @(posedge i_clk) begin
        r_y[0] <= lerp16(r_x[0], r_x[1], r_sy6);
        r_y[1] <= lerp16(r_x[2], r_x[3], r_sy6);
        r_sz7  <= r_sz6;
    end

    // Stage 8: blend along z
    always_ff @(posedge i_clk) begin
        r_v <= lerp16(r_y[0], r_y[1], r_sz7);
    end

    assign o_value = r_v;

endmodule

// ===== rtl/fractal_value_noise_3d.sv =====
// Top level of the fractal value noise block: configuration, octave units, sum, fold.
// Depends on fvn_pkg and fvn_octave.
//
// Takes one direction item per clock and returns one noise item for each accepted
// item. The item passes through the octave units (scale, split, corner hash with
// two mixer multiplies, three blend steps), then the registered octave sum and the
// registered ridged fold. busy never rises, so an item may be started every
// cycle. o_valid marks each result for one cycle; the receiver cannot stall it and
// must take it then. Write configuration only while no item is in flight.
module fractal_value_noise_3d #(
    parameter int OCTAVES = fvn_pkg::OCTAVES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_dir_x,
    input  logic [15:0] i_dir_y,
    input  logic [15:0] i_dir_z,
    output logic        o_valid,
    output logic [15:0] o_noise_value,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import fvn_pkg::*;

    localparam int SUMW = 16 + OCT_MAX + 1;

    logic [31:0]        r_seed;
    logic [15:0]        r_freq;
    logic               r_ridged;
    t_cfg               w_cfg;
    t_dir               w_dir [3];
    logic [15:0]        w_oct [OCTAVES];
    logic [BLK_LAT-1:0] r_vld;
    logic [SUMW-1:0]    w_total;
    logic [15:0]        r_n;
    logic [16:0]        w_fold;
    logic [15:0]        r_out;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Write configuration registers; ignore indexes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed   <= SEED_RST;
            r_freq   <= FREQ_RST;
            r_ridged <= RIDGE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SEED:   r_seed   <= i_cfg_data;
                CFG_FREQ:   r_freq   <= i_cfg_data[15:0];
                CFG_RIDGED: r_ridged <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    assign w_cfg.seed = r_seed;
    assign w_cfg.freq = r_freq;
    assign w_dir[0]   = $signed(i_dir_x);
    assign w_dir[1]   = $signed(i_dir_y);
    assign w_dir[2]   = $signed(i_dir_z);

    // Advance item valid bits alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[BLK_LAT-2:0], start & ~busy};
        end
    end

    // One unit per octave, all working on the same item
    for (genvar g = 0; g < OCTAVES; g++) begin : g_oct
        fvn_octave #(
            .IDX (g)
        ) u_oct (
            .i_clk   (i_clk),
            .i_dir   (w_dir),
            .i_cfg   (w_cfg),
            .o_value (w_oct[g])
        );
    end

    // Weight octaves by halving amplitude, floor to Q0.16 and saturate
    always_comb begin
        w_total = '0;
        for (int i = 0; i < OCTAVES; i++) begin
            w_total = w_total + (SUMW'(w_oct[i]) << (OCT_MAX - 1 - i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_total[SUMW-1:16+8] != '0) begin
            r_n <= 16'hffff;
        end else begin
            r_n <= w_total[23:8];
        end
    end

    // Fold into ridged noise when selected; 2^17 - 2n is taken modulo 2^17
    assign w_fold = r_n[15] ? (17'd0 - {r_n, 1'b0}) : {r_n, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!r_ridged) begin
            r_out <= r_n;
        end else if (w_fold[16]) begin
            r_out <= 16'hffff;
        end else begin
            r_out <= w_fold[15:0];
        end
    end

    assign o_valid       = r_vld[BLK_LAT-1];
    assign o_noise_value = r_out;

    // Every result traces back to an item started a fixed latency earlier
    a_lat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, BLK_LAT))
        else $error("result without a matching started item");

    // Reset empties the pipeline
    a_rst : assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

endmodule

// ===== dv/fvn_checker.sv =====
// Checker for the fractal value noise block: watches the item, result and config channels.
// Predicts each noise item with its own fixed-point fBm model; depends on fvn_pkg.
`timescale 1ns / 1ps
module fvn_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [15:0] i_dir_x,
    input  logic [15:0] i_dir_y,
    input  logic [15:0] i_dir_z,
    input  logic        o_valid,
    input  logic [15:0] o_noise_value,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import fvn_pkg::*;

    localparam int OCT_COUNT = 6;

    logic [31:0] seed_reg;
    logic [15:0] freq_reg;
    logic        ridge_reg;
    logic [15:0] noise_q[$];
    int          fail_count;
    int          pend_count;

    assign o_fail_count = fail_count;
    assign o_pending    = pend_count;

    // Hash one lattice corner into a Q0.16 value
    function automatic logic [15:0] corner_hash(logic [31:0] sd, logic [31:0] cx,
                                                logic [31:0] cy, logic [31:0] cz);
        logic [31:0] h;
        h = sd ^ (cx * PRIME_X) ^ (cy * PRIME_Y) ^ (cz * PRIME_Z);
        h = h ^ (h >> 16);
        h = h * MIX_A;
        h = h ^ (h >> 15);
        h = h * MIX_B;
        h = h ^ (h >> 16);
        return h[31:16];
    endfunction

    function automatic logic [31:0] smooth_w(logic [31:0] t);
        logic [63:0] tt;
        logic [63:0] num;
        tt  = 64'(t) * 64'(t);
        num = 3 * tt * 64'd65536 - 2 * tt * 64'(t);
        return 32'(num >> 32);
    endfunction

    function automatic logic [31:0] blend(logic [31:0] a, logic [31:0] b, logic [31:0] s);
        logic [63:0] v;
        v = 64'(a) * (64'd65536 - 64'(s)) + 64'(b) * 64'(s);
        return 32'(v >> 16);
    endfunction

    // Floor a Q.25 coordinate to Q.16, add the offset, split into cell and fraction
    function automatic void split_axis(logic signed [63:0] p, logic [31:0] off,
                                       output logic [31:0] lat_pt, output logic [31:0] frac);
        logic [63:0] u;
        logic [63:0] q;
        u      = 64'(p + (64'sd1 <<< 45));
        q      = (u >> 9) + 64'(off);
        frac   = {16'd0, q[15:0]};
        lat_pt = 32'((q >> 16) - (64'd1 << 20));
    endfunction

    function automatic logic [15:0] octave_noise(logic signed [63:0] px,
            logic signed [63:0] py, logic signed [63:0] pz, logic [31:0] sd);
        logic [31:0] cx, cy, cz, fx, fy, fz, sx, sy, sz;
        logic [31:0] c[8];
        logic [31:0] y0, y1;
        split_axis(px, OFF_X, cx, fx);
        split_axis(py, OFF_Y, cy, fy);
        split_axis(pz, OFF_Z, cz, fz);
        sx = smooth_w(fx);
        sy = smooth_w(fy);
        sz = smooth_w(fz);
        for (int k = 0; k < 8; k++)
            c[k] = corner_hash(sd, cx + (k & 1), cy + ((k >> 1) & 1), cz + ((k >> 2) & 1));
        y0 = blend(blend(c[0], c[1], sx), blend(c[2], c[3], sx), sy);
        y1 = blend(blend(c[4], c[5], sx), blend(c[6], c[7], sx), sy);
        return 16'(blend(y0, y1, sz));
    endfunction

    function automatic logic [15:0] fbm_noise(logic [15:0] dx, logic [15:0] dy,
                                              logic [15:0] dz);
        logic signed [63:0] f;
        logic [63:0]        total;
        logic [31:0]        n;
        logic [31:0]        r;
        total = 0;
        for (int i = 0; i < OCT_COUNT; i++) begin
            f = 64'(freq_reg) << i;
            total += 64'(octave_noise(64'($signed(dx)) * f, 64'($signed(dy)) * f,
                                      64'($signed(dz)) * f, seed_reg + i * SEED_STEP))
                     << (7 - i);
        end
        total = total >> 8;
        n = (total > 65535) ? 32'd65535 : 32'(total);
        if (ridge_reg) begin
            r = (n < 32768) ? 2 * n : 32'd131072 - 2 * n;
            n = (r > 65535) ? 32'd65535 : r;
        end
        return n[15:0];
    endfunction

    // Track config, predict accepted items, compare results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seed_reg  <= SEED_RST;
            freq_reg  <= FREQ_RST;
            ridge_reg <= RIDGE_RST;
            noise_q.delete();
            fail_count <= 0;
            pend_count <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SEED:   seed_reg  <= i_cfg_data;
                    CFG_FREQ:   freq_reg  <= i_cfg_data[15:0];
                    CFG_RIDGED: ridge_reg <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (start && !busy)
                noise_q.push_back(fbm_noise(i_dir_x, i_dir_y, i_dir_z));
            if (o_valid) begin
                if (noise_q.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result noise=%0d", o_noise_value);
                end else begin
                    if (noise_q[0] !== o_noise_value) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("noise mismatch: exp %0d got %0d", noise_q[0],
                                     o_noise_value);
                    end
                    void'(noise_q.pop_front());
                end
            end
            pend_count <= noise_q.size();
        end
    end
endmodule

// ===== dv/tb.sv =====
// Top of the fractal value noise testbench: clock, reset, stimulus and verdict.
// Depends on fvn_pkg, fractal_value_noise_3d and fvn_checker.
`timescale 1ns / 1ps
module tb;
    import fvn_pkg::*;

    localparam int RAND_ITEMS = 1520;
    localparam int STALL_LIMIT = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [15:0] i_dir_x, i_dir_y, i_dir_z;
    logic        o_valid;
    logic [15:0] o_noise_value;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    int          item_count;

    fractal_value_noise_3d dut (.*);

    fvn_checker checker_i (
        .i_clk, .i_rst_n, .start, .busy, .i_dir_x, .i_dir_y, .i_dir_z, .o_valid,
        .o_noise_value, .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0; #2;
        i_clk = 1'b1; #2;
    end

    // Watchdog: count cycles with no accepted item, result or write
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Send one direction item, then hold off a random gap
    task automatic send_dir(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        int gap;
        start   <= 1'b1;
        i_dir_x <= x;
        i_dir_y <= y;
        i_dir_z <= z;
        do @(posedge i_clk); while (busy);
        item_count++;
        gap = $urandom_range(0, 7);
        if (item_count % 200 > 150) gap = 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain the pipe, then write one register
    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (BLK_LAT + 2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_dir();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] freqs[6];
        freqs = '{16'd0, 16'd65535, 16'd2560, 16'd1, 16'd1024, 16'd40000};
        item_count  = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_dir_x     = '0;
        i_dir_y     = '0;
        i_dir_z     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SEED;
        i_cfg_data  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes at reset config
        send_dir(16'h0000, 16'h0000, 16'h0000);
        send_dir(16'h8000, 16'h8000, 16'h8000);
        send_dir(16'h7fff, 16'h7fff, 16'h7fff);
        send_dir(16'h8000, 16'h7fff, 16'h0001);
        send_dir(16'hffff, 16'h0001, 16'h8000);
        send_dir(16'h5555, 16'haaaa, 16'h1234);
        // Zero frequency samples the offset point only
        write_reg(CFG_FREQ, 32'd0);
        send_dir(16'h7fff, 16'h8000, 16'h1111);
        send_dir(16'h0000, 16'h0000, 16'h0000);
        // Ridged fold with max frequency and seed
        write_reg(CFG_RIDGED, 32'd1);
        write_reg(CFG_FREQ, 32'hffff_ffff);
        write_reg(CFG_SEED, 32'hffff_ffff);
        for (int i = 0; i < 8; i++) send_dir(rand_dir(), rand_dir(), rand_dir());
        // Out-of-list index must be ignored
        write_reg(t_cfg_idx'(2'd3), 32'h0000_1234);
        for (int i = 0; i < 4; i++) send_dir(rand_dir(), rand_dir(), rand_dir());

        // Random phases across settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_SEED, (ph == 1) ? 32'd0 : $urandom);
            write_reg(CFG_FREQ, (ph < 6) ? 32'(freqs[ph]) : 32'($urandom));
            write_reg(CFG_RIDGED, ph % 2);
            for (int i = 0; i < RAND_ITEMS / 8; i++)
                send_dir(rand_dir(), rand_dir(), rand_dir());
        end
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (BLK_LAT + 4) @(posedge i_clk);

        $display("Ran %0d direction items over eight seed/frequency/ridge settings,",
                 item_count);
        $display("including zero and full-scale frequency and both fold modes.");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
